// File: rtl/knbs_pkg.sv
// Shared types and constants for the k-nearest bounded selector.
package knbs_pkg;

   localparam int CFG_W   = 7;
   localparam int DIST_W  = 32;
   localparam int SLOT_W  = 6;
   localparam int FOUND_W = 7;

   localparam logic [CFG_W-1:0] KEEP_RESET = 7'd50;

   // controller to datapath
   typedef struct packed {
      logic accept;       // latch request fields
      logic exec;         // carry out the latched request
      logic rd_capture;   // take slot read data
      logic scan_step;    // one step of the farthest-entry rescan
      logic scan_commit;  // rescan finished, adopt its maximum
      logic load_out;     // load result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_read;
      logic full;
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

// File: rtl/k_nearest_bounded_selector_core.sv
// Top level of the k-nearest bounded selector: controller plus datapath.
//
// Keeps up to keep_count candidates of one neighbour search in a RAM of
// MAX_KEEP entries and tracks the squared search radius. A request either
// offers a candidate (start_new first empties the store and loads the radius)
// or reads one stored slot; each request yields exactly one response. An
// offer to a store that is not yet full goes from execution to the response;
// a slot read first waits for the registered RAM read data. An offer to a
// full store evicts the farthest entry and then rescans every stored entry
// through the single RAM read port to find the new farthest. The response
// register holds a result under rsp_stall while the next request is taken.
// The store needs no clearing after reset; unfilled slots' data is never used.
module k_nearest_bounded_selector_core import knbs_pkg::*; #(
   parameter int MAX_KEEP = 64,
   parameter int ID_BITS  = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CFG_W-1:0]   csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic               req_start_new,
   input  logic [DIST_W-1:0]  req_radius_sq,
   input  logic [ID_BITS-1:0] req_cand_id,
   input  logic [DIST_W-1:0]  req_cand_dist_sq,
   input  logic [SLOT_W-1:0]  req_slot,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FOUND_W-1:0] rsp_found_count,
   output logic               rsp_full_res,
   output logic [DIST_W-1:0]  rsp_max_dist_sq,
   output logic [ID_BITS-1:0] rsp_entry_id,
   output logic [DIST_W-1:0]  rsp_entry_dist_sq
);

   cmd_type    cmd;
   status_type status;

   knbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   knbs_datapath #(
      .MAX_KEEP (MAX_KEEP),
      .ID_BITS  (ID_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .req_mode          (req_mode),
      .req_start_new     (req_start_new),
      .req_radius_sq     (req_radius_sq),
      .req_cand_id       (req_cand_id),
      .req_cand_dist_sq  (req_cand_dist_sq),
      .req_slot          (req_slot),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found_count   (rsp_found_count),
      .rsp_full_res      (rsp_full_res),
      .rsp_max_dist_sq   (rsp_max_dist_sq),
      .rsp_entry_id      (rsp_entry_id),
      .rsp_entry_dist_sq (rsp_entry_dist_sq),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// File: rtl/knbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module knbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/knbs_ctrl.sv
// Sequencing controller for the k-nearest bounded selector.
module knbs_ctrl import knbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RD_WAIT,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            priority if (status.is_read) begin
               state_in = ST_RD_WAIT;
            end else if (status.full) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RD_WAIT: begin
            cmd.rd_capture = 1'b1;
            state_in       = ST_RESP;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               cmd.scan_commit = 1'b1;
               state_in        = ST_RESP;
            end
         end
         ST_RESP: begin
            // result goes out while the next request is taken
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               req_stall    = 1'b0;
               cmd.accept   = req_valid;
               state_in     = req_valid ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/knbs_datapath.sv
// Datapath: entry store, count, radius, farthest-entry tracking and rescan.
module knbs_datapath import knbs_pkg::*; #(
   parameter int MAX_KEEP = 64,
   parameter int ID_BITS  = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_data,
   input  logic                req_mode,
   input  logic                req_start_new,
   input  logic [DIST_W-1:0]   req_radius_sq,
   input  logic [ID_BITS-1:0]  req_cand_id,
   input  logic [DIST_W-1:0]   req_cand_dist_sq,
   input  logic [SLOT_W-1:0]   req_slot,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [FOUND_W-1:0]  rsp_found_count,
   output logic                rsp_full_res,
   output logic [DIST_W-1:0]   rsp_max_dist_sq,
   output logic [ID_BITS-1:0]  rsp_entry_id,
   output logic [DIST_W-1:0]   rsp_entry_dist_sq,
   input  cmd_type             cmd,
   output status_type          status
);

   localparam int AW = $clog2(MAX_KEEP);
   localparam int CW = $clog2(MAX_KEEP + 1);
   localparam int KW = (CW > CFG_W) ? CW : CFG_W;
   localparam int RW = ID_BITS + DIST_W;
   localparam logic [KW-1:0] MAX_K = KW'(MAX_KEEP);

   // configuration
   logic [CFG_W-1:0]   keep_ff;

   // latched request
   logic               mode_ff, start_ff;
   logic [DIST_W-1:0]  rad_ff, dist_ff;
   logic [ID_BITS-1:0] id_ff;
   logic [SLOT_W-1:0]  slot_ff;

   // search state
   logic [CW-1:0]      count_ff, count_in;
   logic [DIST_W-1:0]  radius_ff, radius_in;
   logic [AW-1:0]      max_slot_ff, max_slot_in;
   logic [DIST_W-1:0]  max_dist_ff, max_dist_in;

   // rescan
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [AW-1:0]      rd_idx_ff;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [AW-1:0]      best_slot_ff, best_slot_in;

   // slot read
   logic               in_range_ff;
   logic [ID_BITS-1:0] rid_ff, rid_in;
   logic [DIST_W-1:0]  rdist_ff, rdist_in;

   logic               rsp_valid_ff;

   logic [KW-1:0]      keep_ext, keff, slot_k;
   logic [CW-1:0]      base, next_cnt;
   logic               full, in_range, new_max, scan_issue, take, out_free;
   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [RW-1:0]      ram_rdata;
   logic [DIST_W-1:0]  rd_dist;

   assign csr_ready = 1'b1;

   assign keep_ext = KW'(keep_ff);

   always_comb begin
      priority if (keep_ext == '0) begin
         keff = KW'(1);
      end else if (keep_ext > MAX_K) begin
         keff = MAX_K;
      end else begin
         keff = keep_ext;
      end
   end

   // start flag empties the store before the offer
   assign base     = start_ff ? '0 : count_ff;
   assign full     = KW'(base) >= keff;
   assign next_cnt = CW'(base + CW'(1));
   assign new_max  = (base == '0) || (dist_ff > max_dist_ff);

   assign slot_k   = KW'(slot_ff);
   assign in_range = slot_k < KW'(count_ff);

   assign scan_issue = cmd.scan_step && (scan_idx_ff < count_ff);
   assign rd_dist    = ram_rdata[DIST_W-1:0];
   // strict compare keeps the lowest slot among equal maxima
   assign take       = (rd_idx_ff == '0) || (rd_dist > best_dist_ff);

   assign ram_we    = cmd.exec && !mode_ff;
   assign ram_waddr = full ? max_slot_ff : base[AW-1:0];
   assign ram_re    = (cmd.exec && mode_ff) || scan_issue;
   assign ram_raddr = cmd.exec ? slot_k[AW-1:0] : scan_idx_ff[AW-1:0];

   knbs_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_KEEP)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({id_ff, dist_ff}),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      count_in     = count_ff;
      radius_in    = radius_ff;
      max_slot_in  = max_slot_ff;
      max_dist_in  = max_dist_ff;
      scan_idx_in  = scan_idx_ff;
      rd_pend_in   = scan_issue;
      best_dist_in = best_dist_ff;
      best_slot_in = best_slot_ff;
      rid_in       = rid_ff;
      rdist_in     = rdist_ff;

      if (cmd.exec) begin
         scan_idx_in = '0;
         rd_pend_in  = 1'b0;
         if (!mode_ff) begin
            rid_in   = '0;
            rdist_in = '0;
            if (!full) begin
               count_in = next_cnt;
               if (new_max) begin
                  max_slot_in = base[AW-1:0];
                  max_dist_in = dist_ff;
               end
               priority if (KW'(next_cnt) == keff) begin
                  radius_in = new_max ? dist_ff : max_dist_ff;
               end else if (start_ff) begin
                  radius_in = rad_ff;
               end else begin
                  radius_in = radius_ff;
               end
            end
         end
      end

      if (scan_issue) begin
         scan_idx_in = CW'(scan_idx_ff + CW'(1));
      end

      if (rd_pend_ff && take) begin
         best_dist_in = rd_dist;
         best_slot_in = rd_idx_ff;
      end

      if (cmd.scan_commit) begin
         radius_in   = best_dist_ff;
         max_dist_in = best_dist_ff;
         max_slot_in = best_slot_ff;
      end

      if (cmd.rd_capture) begin
         rid_in   = in_range_ff ? ram_rdata[RW-1:DIST_W] : '0;
         rdist_in = in_range_ff ? rd_dist : '0;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff      <= KEEP_RESET;
         count_ff     <= '0;
         radius_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            keep_ff <= csr_data;
         end
         count_ff   <= count_in;
         radius_ff  <= radius_in;
         rd_pend_ff <= rd_pend_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff  <= req_mode;
         start_ff <= req_start_new;
         rad_ff   <= req_radius_sq;
         id_ff    <= req_cand_id;
         dist_ff  <= req_cand_dist_sq;
         slot_ff  <= req_slot;
      end
      if (cmd.exec) begin
         in_range_ff <= in_range;
      end
      max_slot_ff  <= max_slot_in;
      max_dist_ff  <= max_dist_in;
      scan_idx_ff  <= scan_idx_in;
      rd_idx_ff    <= scan_idx_ff[AW-1:0];
      best_dist_ff <= best_dist_in;
      best_slot_ff <= best_slot_in;
      rid_ff       <= rid_in;
      rdist_ff     <= rdist_in;
      if (cmd.load_out) begin
         rsp_found_count   <= FOUND_W'(count_ff);
         rsp_full_res      <= KW'(count_ff) >= keff;
         rsp_max_dist_sq   <= radius_ff;
         rsp_entry_id      <= rid_ff;
         rsp_entry_dist_sq <= rdist_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign status.is_read   = mode_ff;
   assign status.full      = full;
   assign status.scan_done = (scan_idx_ff == count_ff) && !rd_pend_ff;
   assign status.out_free  = out_free;

endmodule

// File: sim/knbs_tb_pkg.sv
`timescale 1ns / 100ps
// Request codes shared by the selector stimulus and its checker.
package knbs_tb_pkg;

   typedef enum logic {
      OP_OFFER = 1'b0,
      OP_READ  = 1'b1
   } knbs_op_e;

endpackage

// File: sim/knbs_checker.sv
`timescale 1ns / 100ps
// Selector scoreboard: tracks the kept candidates and compares every response transfer.
module knbs_checker import knbs_pkg::*; import knbs_tb_pkg::*; #(
   parameter int MAX_KEEP = 64,
   parameter int ID_BITS  = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [CFG_W-1:0]   csr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_mode,
   input  logic               req_start_new,
   input  logic [DIST_W-1:0]  req_radius_sq,
   input  logic [ID_BITS-1:0] req_cand_id,
   input  logic [DIST_W-1:0]  req_cand_dist_sq,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [FOUND_W-1:0] rsp_found_count,
   input  logic               rsp_full_res,
   input  logic [DIST_W-1:0]  rsp_max_dist_sq,
   input  logic [ID_BITS-1:0] rsp_entry_id,
   input  logic [DIST_W-1:0]  rsp_entry_dist_sq,
   output int unsigned        errors,
   output int unsigned        outstanding,
   output int unsigned        responses
);

   typedef struct packed {
      logic [FOUND_W-1:0] found;
      logic               full;
      logic [DIST_W-1:0]  radius;
      logic [ID_BITS-1:0] id;
      logic [DIST_W-1:0]  edist;
   } sel_result_t;

   logic [CFG_W-1:0]   keep_q;
   logic [FOUND_W-1:0] stored_n;
   logic [DIST_W-1:0]  radius_q;
   logic [ID_BITS-1:0] slot_id   [MAX_KEEP];
   logic [DIST_W-1:0]  slot_dist [MAX_KEEP];
   sel_result_t        pending_results [$];

   function automatic int keep_limit();
      int k = int'(keep_q);
      if (k == 0) k = 1;
      if (k > MAX_KEEP) k = MAX_KEEP;
      return k;
   endfunction

   // lowest slot holding the largest distance
   function automatic int farthest_slot();
      int best = 0;
      for (int i = 1; i < int'(stored_n) && i < MAX_KEEP; i++)
         if (slot_dist[i] > slot_dist[best]) best = i;
      return best;
   endfunction

   function automatic sel_result_t select_step(knbs_op_e op, logic start,
         logic [DIST_W-1:0] rad, logic [ID_BITS-1:0] cid, logic [DIST_W-1:0] cdist,
         logic [SLOT_W-1:0] rd_slot);
      int k = keep_limit();
      int s;
      sel_result_t r = '0;
      if (op == OP_OFFER) begin
         if (start) begin
            stored_n = '0;
            radius_q = rad;
         end
         if (int'(stored_n) < k) begin
            slot_id[stored_n]   = cid;
            slot_dist[stored_n] = cdist;
            stored_n = stored_n + 1'b1;
            if (int'(stored_n) == k) radius_q = slot_dist[farthest_slot()];
         end else begin
            // full (or over-full after keep was lowered): evict regardless of distance
            s = farthest_slot();
            slot_id[s]   = cid;
            slot_dist[s] = cdist;
            radius_q = slot_dist[farthest_slot()];
         end
      end else if (int'(rd_slot) < int'(stored_n) && int'(rd_slot) < MAX_KEEP) begin
         r.id    = slot_id[rd_slot];
         r.edist = slot_dist[rd_slot];
      end
      r.found  = stored_n;
      r.full   = (int'(stored_n) >= k);
      r.radius = radius_q;
      return r;
   endfunction

   task automatic check_field(string what, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      sel_result_t want;
      sel_result_t due;
      if (reset) begin
         keep_q      = KEEP_RESET;
         stored_n    = '0;
         radius_q    = '0;
         pending_results.delete();
         outstanding = 0;
      end else begin
         // response first: it always belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            responses++;
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, actual count %0d radius %0h",
                        $time, rsp_found_count, rsp_max_dist_sq);
            end else begin
               want = pending_results.pop_front();
               check_field("found_count", want.found, rsp_found_count);
               check_field("full_res", want.full, rsp_full_res);
               check_field("max_dist_sq", want.radius, rsp_max_dist_sq);
               check_field("entry_id", want.id, rsp_entry_id);
               check_field("entry_dist_sq", want.edist, rsp_entry_dist_sq);
            end
         end
         if (csr_valid && csr_ready) keep_q = csr_data;
         if (req_valid && !req_stall) begin
            due = select_step(knbs_op_e'(req_mode), req_start_new,
               req_radius_sq, req_cand_id, req_cand_dist_sq, req_slot);
            pending_results = {pending_results, due};
         end
         outstanding = pending_results.size();
      end
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Top of the selector testbench: clock, reset, stimulus, flow control and verdict.
module tb;
   import knbs_pkg::*;
   import knbs_tb_pkg::*;

   localparam int MAX_KEEP    = 64;
   localparam int ID_BITS     = 20;
   localparam int RUN_LIMIT   = 600000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 100;
   localparam int SEGMENTS    = 8;
   localparam int SEG_ITEMS   = 92;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               csr_valid        = 1'b0;
   logic [CFG_W-1:0]   csr_data         = '0;
   logic               req_valid        = 1'b0;
   logic               req_mode         = 1'b0;
   logic               req_start_new    = 1'b0;
   logic [DIST_W-1:0]  req_radius_sq    = '0;
   logic [ID_BITS-1:0] req_cand_id      = '0;
   logic [DIST_W-1:0]  req_cand_dist_sq = '0;
   logic [SLOT_W-1:0]  req_slot         = '0;
   logic               rsp_stall        = 1'b0;

   logic               csr_ready;
   logic               req_stall;
   logic               rsp_valid;
   logic [FOUND_W-1:0] rsp_found_count;
   logic               rsp_full_res;
   logic [DIST_W-1:0]  rsp_max_dist_sq;
   logic [ID_BITS-1:0] rsp_entry_id;
   logic [DIST_W-1:0]  rsp_entry_dist_sq;

   int unsigned errors, outstanding, responses;
   int unsigned cycle_n   = 0;
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_asks = 0;
   int unsigned hold_done = 0;
   int unsigned hold_left = 0;
   int unsigned sent      = 0;
   int          keep_eff  = 50;   // stimulus-side view of the clamped keep count
   int          search_left = 0;
   logic [DIST_W-1:0] search_rad = '0;

   logic [CFG_W-1:0] keep_plan  [SEGMENTS];
   int unsigned      idle_plan  [4];
   int unsigned      stall_plan [4];

   always #5 clock = ~clock;

   always @(posedge clock) cycle_n <= cycle_n + 1;

   k_nearest_bounded_selector_core #(
      .MAX_KEEP (MAX_KEEP),
      .ID_BITS  (ID_BITS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_start_new     (req_start_new),
      .req_radius_sq     (req_radius_sq),
      .req_cand_id       (req_cand_id),
      .req_cand_dist_sq  (req_cand_dist_sq),
      .req_slot          (req_slot),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found_count   (rsp_found_count),
      .rsp_full_res      (rsp_full_res),
      .rsp_max_dist_sq   (rsp_max_dist_sq),
      .rsp_entry_id      (rsp_entry_id),
      .rsp_entry_dist_sq (rsp_entry_dist_sq)
   );

   knbs_checker #(
      .MAX_KEEP (MAX_KEEP),
      .ID_BITS  (ID_BITS)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_start_new     (req_start_new),
      .req_radius_sq     (req_radius_sq),
      .req_cand_id       (req_cand_id),
      .req_cand_dist_sq  (req_cand_dist_sq),
      .req_slot          (req_slot),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found_count   (rsp_found_count),
      .rsp_full_res      (rsp_full_res),
      .rsp_max_dist_sq   (rsp_max_dist_sq),
      .rsp_entry_id      (rsp_entry_id),
      .rsp_entry_dist_sq (rsp_entry_dist_sq),
      .errors            (errors),
      .outstanding       (outstanding),
      .responses         (responses)
   );

   // receiver: random stall, or a counted hold-off when one is asked for
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_done != hold_asks) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= hold_done + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_req(input knbs_op_e op, input logic start, input logic [DIST_W-1:0] rad,
                           input logic [ID_BITS-1:0] cid, input logic [DIST_W-1:0] cdist,
                           input logic [SLOT_W-1:0] rd_slot);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= op;
      req_start_new    <= start;
      req_radius_sq    <= rad;
      req_cand_id      <= cid;
      req_cand_dist_sq <= cdist;
      req_slot         <= rd_slot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      if (outstanding != 0) begin
         req_valid <= 1'b0;
         while (outstanding != 0) @(negedge clock);
      end
   endtask

   // only written with the block idle
   task automatic set_keep(input logic [CFG_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      keep_eff = (v == 0) ? 1 : ((int'(v) > MAX_KEEP) ? MAX_KEEP : int'(v));
   endtask

   initial begin
      wait (cycle_n >= RUN_LIMIT);
      $display("timeout after %0d cycles, %0d results still due", cycle_n, outstanding);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int pick;
      logic [DIST_W-1:0] d;
      logic fresh;
      keep_plan  = '{7'd5, 7'd0, 7'd127, 7'd2, 7'd12, 7'd64, 7'd3, 7'd1};
      idle_plan  = '{0, 87, 0, 23};
      stall_plan = '{0, 0, 87, 23};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // straight after reset: append with radius zero, start flag on a read, unfilled slot
      send_req(OP_OFFER, 1'b0, 32'h0, 20'hFFFFF, 32'hFFFF_FFFF, 6'h00);
      send_req(OP_READ, 1'b1, 32'hFFFF_FFFF, 20'h00000, 32'h0, 6'h00);
      send_req(OP_READ, 1'b0, 32'h0, 20'h00000, 32'h0, 6'h3F);

      set_keep(7'd3);
      send_req(OP_OFFER, 1'b1, 32'hFFFF_FFFF, 20'h00000, 32'h0000_0000, 6'h3F);
      send_req(OP_OFFER, 1'b0, 32'h0, 20'h12345, 32'h0004_0000, 6'h00);
      send_req(OP_OFFER, 1'b0, 32'h0, 20'hABCDE, 32'h0004_0000, 6'h00); // fills, tie on max
      send_req(OP_OFFER, 1'b0, 32'h0, 20'h00001, 32'h0001_0000, 6'h00); // lower tied slot goes
      send_req(OP_OFFER, 1'b0, 32'h0, 20'h00002, 32'hFFFF_FFFF, 6'h00); // beyond the radius
      for (int i = 0; i < 4; i++)
         send_req(OP_READ, 1'b0, 32'h0, 20'h0, 32'h0, SLOT_W'(i));

      // keep below the stored count: store stays over-full
      set_keep(7'd1);
      send_req(OP_OFFER, 1'b0, 32'h0, 20'h55555, 32'h0000_0001, 6'h00);
      send_req(OP_OFFER, 1'b0, 32'h0, 20'hAAAAA, 32'h7FFF_FFFF, 6'h00);
      send_req(OP_READ, 1'b0, 32'h0, 20'h0, 32'h0, 6'h02);

      // zero keep acts as one
      set_keep(7'd0);
      send_req(OP_OFFER, 1'b1, 32'h8000_0000, 20'h0F0F0, 32'h0000_FFFF, 6'h2A);
      send_req(OP_OFFER, 1'b0, 32'h0, 20'hF0F0F, 32'h0000_0010, 6'h15);
      send_req(OP_READ, 1'b0, 32'h0, 20'h0, 32'h0, 6'h00);
      send_req(OP_READ, 1'b0, 32'h0, 20'h0, 32'h0, 6'h01);

      // oversized keep clamps to the store size
      set_keep(7'h7F);
      send_req(OP_OFFER, 1'b1, 32'h0000_0000, 20'h00FFF, 32'h0000_0000, 6'h00);
      send_req(OP_READ, 1'b0, 32'h0, 20'h0, 32'h0, 6'h00);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         set_keep(keep_plan[seg]);
         idle_pct = idle_plan[seg % 4];
         stall_pct <= stall_plan[seg % 4];
         search_left = 0;
         for (int n = 0; n < SEG_ITEMS; n++) begin
            // long receiver hold-off while the sender keeps going: fills the block
            if (seg == 0 && n == 20) hold_asks <= hold_asks + 1;
            // sender pauses until every result is back
            if (seg == 4 && n == 45) drain();
            pick = $urandom_range(99);
            if (pick < 5) begin
               send_req(knbs_op_e'($urandom_range(1)), 1'($urandom), $urandom,
                        ID_BITS'($urandom), $urandom, SLOT_W'($urandom));
            end else if (pick < 25) begin
               send_req(OP_READ, 1'($urandom), $urandom, ID_BITS'($urandom), $urandom,
                        ($urandom_range(9) == 0) ? SLOT_W'($urandom)
                                                 : SLOT_W'($urandom_range(keep_eff - 1)));
            end else begin
               fresh = (search_left == 0);
               if (fresh) begin
                  search_rad  = ($urandom_range(3) == 0) ? '1 : $urandom;
                  search_left = $urandom_range(2 * keep_eff + 3, 1);
               end
               if (pick < 30) d = $urandom;
               else d = (search_rad == 0) ? '0 : $urandom % search_rad;
               send_req(OP_OFFER, fresh, search_rad,
                        ID_BITS'($urandom), d, SLOT_W'($urandom));
               search_left--;
            end
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("run covered %0d requests and %0d responses over %0d keep settings,",
               sent, responses, SEGMENTS + 5);
      $display("including over-full store, clamped keep and stalls from both sides");
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: sim.f
rtl/knbs_pkg.sv
rtl/knbs_ram.sv
rtl/knbs_ctrl.sv
rtl/knbs_datapath.sv
rtl/k_nearest_bounded_selector_core.sv
sim/knbs_tb_pkg.sv
sim/knbs_checker.sv
sim/tb.sv
